[sv/hcsg_pkg.sv]
`default_nettype none

package hcsg_pkg;

    // field and register widths
    localparam int LEN_W        = 10;
    localparam int ORD_CFG_W    = 4;
    localparam int PEN_W        = 19;
    localparam int Y_W          = 18;
    localparam int REG_IDX_W    = 1;

    localparam int MAX_ORDER_DEF = 8;

    // register indexes of the config port
    localparam logic [REG_IDX_W-1:0] REG_CURVE_ORDER    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_LENGTH = 1'd1;

    // register reset values
    localparam logic [ORD_CFG_W-1:0] CURVE_ORDER_RST    = 4'd1;
    localparam logic [LEN_W-1:0]     INITIAL_LENGTH_RST = 10'd128;

    // phase value that marks a bracket with all three moves made
    localparam logic [1:0] PH_DONE = 2'd3;

    // pen move codes
    localparam logic [1:0] MV_XN = 2'd0;
    localparam logic [1:0] MV_XP = 2'd1;
    localparam logic [1:0] MV_YN = 2'd2;
    localparam logic [1:0] MV_YP = 2'd3;

    typedef enum logic [1:0] {
        BRK_A = 2'd0,
        BRK_B = 2'd1,
        BRK_C = 2'd2,
        BRK_D = 2'd3
    } brk_t;

    // descent handed from a level to the next deeper one
    typedef struct packed {
        logic vld;
        brk_t typ;
    } desc_t;

    // pen move collected along the row
    typedef struct packed {
        logic       vld;
        logic [1:0] code;
    } mv_t;

    // per-cell control
    typedef struct packed {
        logic step;
        logic bottom;
    } cell_ctl_t;

    // bracket type of sub-bracket q inside a bracket of type t
    function automatic brk_t sub_brk(input brk_t t, input logic [1:0] q);
        brk_t r;
        r = BRK_A;
        case (t)
            BRK_A:
            begin
                case (q)
                    2'd0:    r = BRK_D;
                    2'd1:    r = BRK_A;
                    2'd2:    r = BRK_A;
                    default: r = BRK_B;
                endcase
            end
            BRK_B:
            begin
                case (q)
                    2'd0:    r = BRK_C;
                    2'd1:    r = BRK_B;
                    2'd2:    r = BRK_B;
                    default: r = BRK_A;
                endcase
            end
            BRK_C:
            begin
                case (q)
                    2'd0:    r = BRK_B;
                    2'd1:    r = BRK_C;
                    2'd2:    r = BRK_C;
                    default: r = BRK_D;
                endcase
            end
            default:
            begin
                case (q)
                    2'd0:    r = BRK_A;
                    2'd1:    r = BRK_D;
                    2'd2:    r = BRK_D;
                    default: r = BRK_C;
                endcase
            end
        endcase
        return r;
    endfunction

    // move made by a bracket of type t at phase p (p at most 2)
    function automatic logic [1:0] move_code(input brk_t t, input logic [1:0] p);
        logic [1:0] r;
        r = MV_XN;
        case (t)
            BRK_A:
            begin
                case (p)
                    2'd0:    r = MV_XN;
                    2'd1:    r = MV_YP;
                    default: r = MV_XP;
                endcase
            end
            BRK_B:
            begin
                case (p)
                    2'd0:    r = MV_YN;
                    2'd1:    r = MV_XP;
                    default: r = MV_YP;
                endcase
            end
            BRK_C:
            begin
                case (p)
                    2'd0:    r = MV_XP;
                    2'd1:    r = MV_YN;
                    default: r = MV_XN;
                endcase
            end
            default:
            begin
                case (p)
                    2'd0:    r = MV_YP;
                    2'd1:    r = MV_XN;
                    default: r = MV_YN;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/hcsg_cell.sv]
`default_nettype none

module hcsg_cell
    import hcsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  desc_t     desc_in,
    output desc_t     desc_out,
    input  logic      srch_in,
    output logic      srch_out,
    input  mv_t       mv_in,
    output mv_t       mv_out,
    output logic      active
);

    brk_t       typ_reg, typ_next;
    logic [1:0] ph_reg, ph_next;
    logic       act_reg, act_next;

    logic [1:0] ph_eff;
    logic [1:0] ph_inc;
    logic       my_step;
    logic       claim;

    assign ph_eff  = (ph_reg == PH_DONE) ? 2'd2 : ph_reg;
    assign ph_inc  = ph_eff + 2'd1;
    assign my_step = ctl.step & act_reg;
    // climb stops at the first level that still owes a move
    assign claim   = srch_in & (ph_reg != PH_DONE);

    always_comb
    begin
        desc_out = '{vld: 1'b0, typ: BRK_A};
        if (desc_in.vld)
        begin
            desc_out = '{vld: 1'b1, typ: sub_brk(desc_in.typ, 2'd0)};
        end
        else if (my_step && !ctl.bottom)
        begin
            desc_out = '{vld: 1'b1, typ: sub_brk(typ_reg, ph_inc)};
        end
    end

    assign srch_out = (srch_in & ~claim) | (my_step & ctl.bottom & (ph_inc == PH_DONE));
    assign mv_out   = mv_in.vld ? mv_in : mv_t'{vld: my_step, code: move_code(typ_reg, ph_eff)};
    assign active   = act_reg;

    always_comb
    begin
        typ_next = typ_reg;
        ph_next  = ph_reg;
        act_next = act_reg;
        if (desc_in.vld)
        begin
            typ_next = desc_in.typ;
            ph_next  = 2'd0;
            act_next = ctl.bottom;
        end
        else if (claim)
        begin
            act_next = 1'b1;
        end
        else if (my_step)
        begin
            ph_next  = ph_inc;
            act_next = ctl.bottom & (ph_inc != PH_DONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            typ_reg <= BRK_A;
            ph_reg  <= 2'd0;
            act_reg <= 1'b0;
        end
        else
        begin
            typ_reg <= typ_next;
            ph_reg  <= ph_next;
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

[sv/hcsg_scale.sv]
`default_nettype none

module hcsg_scale
    import hcsg_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic [LEN_W-1:0]                 len,
    input  logic [$clog2(MAX_ORDER+1)-1:0]   ord,
    output logic [LEN_W-1:0]                 quot
);

    localparam int OW = $clog2(MAX_ORDER + 1);
    // exact for len < 2^LEN_W and ord <= MAX_ORDER
    localparam int K  = LEN_W + $clog2(MAX_ORDER);
    localparam int RW = K + 1;
    localparam int PW = LEN_W + RW;

    logic [RW-1:0] recip_tab [MAX_ORDER];
    logic [RW-1:0] recip;
    logic [PW-1:0] prod;

    for (genvar d = 1; d <= MAX_ORDER; d++)
    begin : g_recip
        localparam logic [RW-1:0] RC = RW'(((64'd1 << K) + d - 1) / d);
        assign recip_tab[d-1] = RC;
    end

    always_comb
    begin
        recip = '0;
        for (int d = 0; d < MAX_ORDER; d++)
        begin
            if (ord == OW'(d + 1))
            begin
                recip = recip_tab[d];
            end
        end
    end

    assign prod = PW'(len) * PW'(recip);
    assign quot = prod[K+LEN_W-1:K];

endmodule

`default_nettype wire

[sv/hilbert_curve_segment_generator_unit.sv]
// a tick's segment item is loaded into the output stage when the tick is accepted and is shown in the next cycle
// throughput: one segment per cycle while out_ready keeps the output free; a restart tick gives no item
// the active level, its move and the next descent or climb settle along the cell row
// reset: no curve running, ticks give nothing until a restart; order 1, length 128
// no clearing pass is needed after reset
`default_nettype none

module hilbert_curve_segment_generator_unit
    import hcsg_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // config write port
    input  logic                    cfg_wr_en,
    input  logic [REG_IDX_W-1:0]    cfg_index,
    input  logic [LEN_W-1:0]        cfg_data,

    // tick items
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,

    // segment items
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [PEN_W-1:0] start_x,
    output logic [Y_W-1:0]          start_y,
    output logic signed [PEN_W-1:0] end_x,
    output logic [Y_W-1:0]          end_y,
    output logic                    last_segment
);

    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int CW = (OW > ORD_CFG_W) ? OW : ORD_CFG_W;

    // config registers
    logic [ORD_CFG_W-1:0] curve_order_reg;
    logic [LEN_W-1:0]     initial_length_reg;

    // curve state outside the cells
    logic [OW-1:0]        order_reg, order_next;
    logic [LEN_W-1:0]     step_length_reg, step_length_next;
    logic [PEN_W-1:0]     pen_x_reg, pen_x_next;
    logic [PEN_W-1:0]     pen_y_reg, pen_y_next;
    logic                 done_reg, done_next;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic [PEN_W-1:0]     start_x_reg, start_x_next;
    logic [PEN_W-1:0]     start_y_reg, start_y_next;
    logic [PEN_W-1:0]     end_x_reg, end_x_next;
    logic [PEN_W-1:0]     end_y_reg, end_y_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 restart_go;
    logic                 step_go;
    logic [CW-1:0]        cfg_ord_ext;
    logic [OW-1:0]        ord_clamped;
    logic [OW-1:0]        eff_order;
    logic [LEN_W-1:0]     quot;
    logic [PEN_W-1:0]     step_ext;
    logic                 fell_off;

    // cell row chains: descent and moves run toward deeper levels, the climb runs up
    desc_t                desc_c [MAX_ORDER+1];
    mv_t                  mv_c   [MAX_ORDER+1];
    logic                 srch_c [MAX_ORDER+1];
    cell_ctl_t            ctl_c  [MAX_ORDER];
    logic [MAX_ORDER-1:0] act_vec;

    // output register frees up when taken, so a new tick can go in the same cycle
    assign in_ready   = ~out_valid_reg | out_ready;
    assign accept     = in_valid & in_ready;
    assign restart_go = accept & restart;
    assign step_go    = accept & ~restart & ~done_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg    <= CURVE_ORDER_RST;
            initial_length_reg <= INITIAL_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CURVE_ORDER:    curve_order_reg    <= cfg_data[ORD_CFG_W-1:0];
                REG_INITIAL_LENGTH: initial_length_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // order zero acts as one, orders past the row act as the row depth
    always_comb
    begin
        cfg_ord_ext = CW'(curve_order_reg);
        if (cfg_ord_ext == '0)
        begin
            cfg_ord_ext = CW'(1);
        end
        else if (cfg_ord_ext > CW'(MAX_ORDER))
        begin
            cfg_ord_ext = CW'(MAX_ORDER);
        end
    end

    assign ord_clamped = cfg_ord_ext[OW-1:0];
    // on restart the deepest level comes from the new order
    assign eff_order   = restart_go ? ord_clamped : order_reg;

    // step length = initial_length / order, through a reciprocal multiply
    hcsg_scale #(
        .MAX_ORDER (MAX_ORDER)
    ) u_scale (
        .len  (initial_length_reg),
        .ord  (ord_clamped),
        .quot (quot)
    );

    // the row of level cells, level 0 first
    assign desc_c[0]         = '{vld: restart_go, typ: BRK_A};
    assign mv_c[0]           = '{vld: 1'b0, code: MV_XN};
    assign srch_c[MAX_ORDER] = 1'b0;

    for (genvar i = 0; i < MAX_ORDER; i++)
    begin : g_cell
        assign ctl_c[i] = '{step: step_go, bottom: (eff_order == OW'(i + 1))};

        hcsg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl_c[i]),
            .desc_in  (desc_c[i]),
            .desc_out (desc_c[i+1]),
            .srch_in  (srch_c[i+1]),
            .srch_out (srch_c[i]),
            .mv_in    (mv_c[i]),
            .mv_out   (mv_c[i+1]),
            .active   (act_vec[i])
        );
    end

    // climb ran past level 0: the curve is complete
    assign fell_off = srch_c[0];
    assign step_ext = PEN_W'(step_length_reg);

    // pen and curve bookkeeping
    always_comb
    begin
        order_next       = order_reg;
        step_length_next = step_length_reg;
        pen_x_next       = pen_x_reg;
        pen_y_next       = pen_y_reg;
        done_next        = done_reg;
        if (restart_go)
        begin
            order_next       = ord_clamped;
            step_length_next = quot;
            pen_x_next       = '0;
            pen_y_next       = '0;
            done_next        = 1'b0;
        end
        else if (step_go)
        begin
            if (mv_c[MAX_ORDER].vld)
            begin
                case (mv_c[MAX_ORDER].code)
                    MV_XN:   pen_x_next = pen_x_reg - step_ext;
                    MV_XP:   pen_x_next = pen_x_reg + step_ext;
                    MV_YN:   pen_y_next = pen_y_reg - step_ext;
                    default: pen_y_next = pen_y_reg + step_ext;
                endcase
            end
            if (fell_off)
            begin
                done_next = 1'b1;
            end
        end
    end

    // output stage: one segment item per stepping tick
    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        last_next      = last_reg;
        if (step_go)
        begin
            out_valid_next = 1'b1;
            start_x_next   = pen_x_reg;
            start_y_next   = pen_y_reg;
            end_x_next     = pen_x_next;
            end_y_next     = pen_y_next;
            last_next      = fell_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg       <= OW'(1);
            step_length_reg <= '0;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            done_reg        <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            order_reg       <= order_next;
            step_length_reg <= step_length_next;
            pen_x_reg       <= pen_x_next;
            pen_y_reg       <= pen_y_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        end_x_reg   <= end_x_next;
        end_y_reg   <= end_y_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign start_x      = start_x_reg;
    assign start_y      = start_y_reg[Y_W-1:0];
    assign end_x        = end_x_reg;
    assign end_y        = end_y_reg[Y_W-1:0];
    assign last_segment = last_reg;

`ifndef SYNTH
    // at most one level is active at a time
    a_act_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act_vec))
        else $error("more than one active level");

    // a running curve always has exactly one active level
    a_run_has_level: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> $onehot(act_vec))
        else $error("running curve without an active level");

    // a last segment on the output means the curve has ended
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> done_reg)
        else $error("last segment shown while curve still running");

    // ticks after the end of a curve give no item
    a_no_item_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !restart && done_reg) |=> !out_valid_reg)
        else $error("item produced after curve end");
`endif

endmodule

`default_nettype wire
